[rtl/stream_directory_parser_defines.svh]
// ----------------------------------------------------------------------------
// stream directory parser assertion macros
// shared assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef STREAM_DIRECTORY_PARSER_DEFINES_SVH
`define STREAM_DIRECTORY_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SDP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sdp assertion failed");
`define SDP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sdp assertion failed");
`else
`define SDP_ASSERT(label, prop)
`define SDP_ASSERT_ALWAYS(label, prop)
`endif

`endif

[rtl/sdp_pkg.sv]
// ----------------------------------------------------------------------------
// sdp_pkg
// types and constants shared by the stream directory parser
// ----------------------------------------------------------------------------
package sdp_pkg;

  localparam int unsigned MAX_STREAMS_DEF = 1024;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_LIST_LARGE  = 3'd1;
  localparam logic [2:0] ERR_TRUNCATED   = 3'd2;
  localparam logic [2:0] ERR_MANY_STRM   = 3'd3;
  localparam logic [2:0] ERR_SIZES_TRUNC = 3'd4;
  localparam logic [2:0] ERR_BLOCKS_TRUNC = 3'd5;
  localparam logic [2:0] ERR_OUT_OF_RANGE = 3'd6;

  localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [1:0] REG_BLOCK_TOTAL = 2'd1;
  localparam logic [1:0] REG_DIR_SIZE   = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_WORD  = 1'b1;

  localparam logic [31:0] EMPTY_SIZE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

[rtl/stream_directory_parser.sv]
// ----------------------------------------------------------------------------
// stream_directory_parser
// parses a stream directory word by word into per block entries
// ----------------------------------------------------------------------------
// One item at a time: in_ready is low from acceptance until the item's results
// are loaded. A start command, and a stream size that opens a stream's block
// list, wait on the shared 32 step divider that forms block counts; each further
// stream visited during the scan adds a size table read, plus a divide when the
// stream is not empty. A block number passes through the offset multiplier and
// the output register, plus the scan when it closes a stream. Results wait in
// an output register.
module stream_directory_parser
  import sdp_pkg::*;
#(
  parameter int unsigned MAX_STREAMS = MAX_STREAMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_directory_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [9:0]  out_stream_index,
  output logic [31:0] out_stream_size,
  output logic [29:0] out_block_position,
  output logic [31:0] out_block_number,
  output logic [63:0] out_block_offset,
  output logic        out_last_of_stream,
  output logic [2:0]  out_error_code,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "stream_directory_parser_defines.svh"

  localparam int unsigned CNT_W = $clog2(MAX_STREAMS + 1);
  localparam int unsigned IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

  typedef enum logic [1:0] {PH_IDLE, PH_COUNT, PH_SIZES, PH_BLOCKS} phase_t;
  typedef enum logic [2:0] {
    S_IDLE, S_START_DIV, S_ADV, S_ADV_CHK, S_ADV_DIV, S_ADV_EVAL, S_MUL, S_EMIT
  } state_t;

  logic [31:0] block_size_r, block_total_r, dir_size_r;

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] cs_r, cs_nxt;
  logic [33:0] cursor_r, cursor_nxt;
  logic [31:0] left_r, left_nxt;
  logic [29:0] pos_r, pos_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] cur_size_r, cur_size_nxt;
  logic        adv_after_r, adv_after_nxt;

  logic        ent_pend_r, ent_pend_nxt;
  logic [CNT_W-1:0] ent_cs_r, ent_cs_nxt;
  logic [31:0] ent_size_r, ent_size_nxt;
  logic [29:0] ent_pos_r, ent_pos_nxt;
  logic [31:0] ent_num_r, ent_num_nxt;
  logic        ent_los_r, ent_los_nxt;
  logic [63:0] ent_off_r;

  logic        fin_pend_r, fin_pend_nxt;
  logic [1:0]  fin_kind_r, fin_kind_nxt;
  logic [2:0]  fin_err_r, fin_err_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [9:0]  sidx_r, sidx_nxt;
  logic [31:0] ssize_r, ssize_nxt;
  logic [29:0] bpos_r, bpos_nxt;
  logic [31:0] bnum_r, bnum_nxt;
  logic [63:0] boff_r, boff_nxt;
  logic        los_r, los_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        last_r, last_nxt;

  logic [31:0] mem [MAX_STREAMS];
  logic [31:0] rd_data_r;
  logic        mem_we;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic        in_xfer;
  logic        slot_free;
  logic [34:0] table_bytes;
  logic [33:0] dir_left;

  sdp_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready    = (state_r == S_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign cfg_ready   = 1'b1;
  assign slot_free   = !out_valid_r || out_ready;
  assign table_bytes = 35'd4 + {1'b0, in_directory_word, 2'b00};
  assign dir_left    = {2'b00, dir_size_r} - cursor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r  <= 32'd4096;
      block_total_r <= '0;
      dir_size_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCK_SIZE:  block_size_r  <= cfg_data;
        REG_BLOCK_TOTAL: block_total_r <= cfg_data;
        REG_DIR_SIZE:    dir_size_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cs_r[IDX_W-1:0]] <= in_directory_word;
    end
    rd_data_r <= mem[cs_r[IDX_W-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    total_nxt     = total_r;
    cs_nxt        = cs_r;
    cursor_nxt    = cursor_r;
    left_nxt      = left_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    cur_size_nxt  = cur_size_r;
    adv_after_nxt = adv_after_r;
    ent_pend_nxt  = ent_pend_r;
    ent_cs_nxt    = ent_cs_r;
    ent_size_nxt  = ent_size_r;
    ent_pos_nxt   = ent_pos_r;
    ent_num_nxt   = ent_num_r;
    ent_los_nxt   = ent_los_r;
    fin_pend_nxt  = fin_pend_r;
    fin_kind_nxt  = fin_kind_r;
    fin_err_nxt   = fin_err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    sidx_nxt      = sidx_r;
    ssize_nxt     = ssize_r;
    bpos_nxt      = bpos_r;
    bnum_nxt      = bnum_r;
    boff_nxt      = boff_r;
    los_nxt       = los_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    mem_we        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = block_size_r + cur_size_r - 32'd1;
    div_req.divisor  = block_size_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EMIT;
          if (in_command == CMD_START) begin
            phase_nxt  = PH_IDLE;
            total_nxt  = '0;
            cs_nxt     = '0;
            cursor_nxt = '0;
            left_nxt   = '0;
            pos_nxt    = '0;
            if (block_size_r == 32'd0) begin
              fin_pend_nxt = 1'b1;
              fin_kind_nxt = KIND_ERROR;
              fin_err_nxt  = ERR_TRUNCATED;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = dir_size_r + block_size_r - 32'd1;
              state_nxt        = S_START_DIV;
            end
          end else begin
            case (phase_r)
              PH_COUNT: begin
                if (in_directory_word > 32'(MAX_STREAMS)) begin
                  fin_pend_nxt = 1'b1;
                  fin_kind_nxt = KIND_ERROR;
                  fin_err_nxt  = ERR_MANY_STRM;
                  phase_nxt    = PH_IDLE;
                end else if (table_bytes > {3'b000, dir_size_r}) begin
                  fin_pend_nxt = 1'b1;
                  fin_kind_nxt = KIND_ERROR;
                  fin_err_nxt  = ERR_SIZES_TRUNC;
                  phase_nxt    = PH_IDLE;
                end else begin
                  total_nxt  = CNT_W'(in_directory_word);
                  cs_nxt     = '0;
                  cursor_nxt = table_bytes[33:0];
                  if (in_directory_word == 32'd0) begin
                    state_nxt = S_ADV;
                  end else begin
                    phase_nxt = PH_SIZES;
                  end
                end
              end
              PH_SIZES: begin
                mem_we = 1'b1;
                cs_nxt = cs_r + CNT_W'(1);
                if (cs_r + CNT_W'(1) >= total_r) begin
                  cs_nxt    = '0;
                  state_nxt = S_ADV;
                end
              end
              PH_BLOCKS: begin
                if (in_directory_word >= block_total_r) begin
                  fin_pend_nxt = 1'b1;
                  fin_kind_nxt = KIND_ERROR;
                  fin_err_nxt  = ERR_OUT_OF_RANGE;
                  phase_nxt    = PH_IDLE;
                end else begin
                  ent_cs_nxt    = cs_r;
                  ent_size_nxt  = cur_size_r;
                  ent_pos_nxt   = pos_r;
                  ent_num_nxt   = in_directory_word;
                  ent_los_nxt   = (left_r == 32'd1);
                  pos_nxt       = pos_r + 30'd1;
                  left_nxt      = left_r - 32'd1;
                  cursor_nxt    = cursor_r + 34'd4;
                  adv_after_nxt = (left_r == 32'd1);
                  if (left_r == 32'd1) begin
                    cs_nxt = cs_r + CNT_W'(1);
                  end
                  state_nxt = S_MUL;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_START_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_EMIT;
          if ({div_rsp.quotient, 2'b00} > {2'b00, block_size_r}) begin
            fin_pend_nxt = 1'b1;
            fin_kind_nxt = KIND_ERROR;
            fin_err_nxt  = ERR_LIST_LARGE;
          end else if (dir_size_r < 32'd4) begin
            fin_pend_nxt = 1'b1;
            fin_kind_nxt = KIND_ERROR;
            fin_err_nxt  = ERR_TRUNCATED;
          end else begin
            phase_nxt = PH_COUNT;
          end
        end
      end
      S_MUL: begin
        ent_pend_nxt = 1'b1;
        state_nxt    = adv_after_r ? S_ADV : S_EMIT;
      end
      S_ADV: begin
        if (cs_r < total_r) begin
          state_nxt = S_ADV_CHK;
        end else begin
          fin_pend_nxt = 1'b1;
          fin_kind_nxt = KIND_DONE;
          fin_err_nxt  = ERR_NONE;
          phase_nxt    = PH_IDLE;
          state_nxt    = S_EMIT;
        end
      end
      S_ADV_CHK: begin
        cur_size_nxt = rd_data_r;
        if (rd_data_r == EMPTY_SIZE) begin
          cs_nxt    = cs_r + CNT_W'(1);
          state_nxt = S_ADV;
        end else if (block_size_r == 32'd0) begin
          cnt_nxt   = '0;
          state_nxt = S_ADV_EVAL;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = rd_data_r + block_size_r - 32'd1;
          state_nxt        = S_ADV_DIV;
        end
      end
      S_ADV_DIV: begin
        if (div_rsp.done) begin
          cnt_nxt   = div_rsp.quotient;
          state_nxt = S_ADV_EVAL;
        end
      end
      S_ADV_EVAL: begin
        if (cursor_r > {2'b00, dir_size_r} || {cnt_r, 2'b00} > dir_left) begin
          fin_pend_nxt = 1'b1;
          fin_kind_nxt = KIND_ERROR;
          fin_err_nxt  = ERR_BLOCKS_TRUNC;
          phase_nxt    = PH_IDLE;
          state_nxt    = S_EMIT;
        end else if (cnt_r != 32'd0) begin
          left_nxt  = cnt_r;
          pos_nxt   = '0;
          phase_nxt = PH_BLOCKS;
          state_nxt = S_EMIT;
        end else begin
          cs_nxt    = cs_r + CNT_W'(1);
          state_nxt = S_ADV;
        end
      end
      S_EMIT: begin
        if (ent_pend_r) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_ENTRY;
            sidx_nxt      = 10'(ent_cs_r);
            ssize_nxt     = ent_size_r;
            bpos_nxt      = ent_pos_r;
            bnum_nxt      = ent_num_r;
            boff_nxt      = ent_off_r;
            los_nxt       = ent_los_r;
            err_nxt       = ERR_NONE;
            last_nxt      = !fin_pend_r;
            ent_pend_nxt  = 1'b0;
          end
        end else if (fin_pend_r) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = fin_kind_r;
            sidx_nxt      = '0;
            ssize_nxt     = '0;
            bpos_nxt      = '0;
            bnum_nxt      = '0;
            boff_nxt      = '0;
            los_nxt       = 1'b0;
            err_nxt       = fin_err_r;
            last_nxt      = 1'b1;
            fin_pend_nxt  = 1'b0;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      total_r     <= '0;
      cs_r        <= '0;
      cursor_r    <= '0;
      left_r      <= '0;
      pos_r       <= '0;
      adv_after_r <= 1'b0;
      ent_pend_r  <= 1'b0;
      fin_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      total_r     <= total_nxt;
      cs_r        <= cs_nxt;
      cursor_r    <= cursor_nxt;
      left_r      <= left_nxt;
      pos_r       <= pos_nxt;
      adv_after_r <= adv_after_nxt;
      ent_pend_r  <= ent_pend_nxt;
      fin_pend_r  <= fin_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r      <= cnt_nxt;
    cur_size_r <= cur_size_nxt;
    ent_cs_r   <= ent_cs_nxt;
    ent_size_r <= ent_size_nxt;
    ent_pos_r  <= ent_pos_nxt;
    ent_num_r  <= ent_num_nxt;
    ent_los_r  <= ent_los_nxt;
    fin_kind_r <= fin_kind_nxt;
    fin_err_r  <= fin_err_nxt;
    kind_r     <= kind_nxt;
    sidx_r     <= sidx_nxt;
    ssize_r    <= ssize_nxt;
    bpos_r     <= bpos_nxt;
    bnum_r     <= bnum_nxt;
    boff_r     <= boff_nxt;
    los_r      <= los_nxt;
    err_r      <= err_nxt;
    last_r     <= last_nxt;
  end

  // offset multiply, registered in S_MUL ahead of the entry load
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      ent_off_r <= 64'(ent_num_r) * 64'(block_size_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_stream_index   = sidx_r;
  assign out_stream_size    = ssize_r;
  assign out_block_position = bpos_r;
  assign out_block_number   = bnum_r;
  assign out_block_offset   = boff_r;
  assign out_last_of_stream = los_r;
  assign out_error_code     = err_r;
  assign out_last           = last_r;

  `SDP_ASSERT(a_busy_after_xfer, in_xfer |=> !in_ready)
  `SDP_ASSERT(a_div_in_wait, div_rsp.busy |-> (state_r == S_START_DIV || state_r == S_ADV_DIV))
  `SDP_ASSERT(a_entry_no_err, (out_valid_r && kind_r == KIND_ENTRY) |-> err_r == ERR_NONE)

endmodule

[rtl/sdp_div.sv]
// ----------------------------------------------------------------------------
// sdp_div
// restoring 32 bit unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sdp_div
  import sdp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  always_comb begin
    rem_sh   = {rem_r, quo_r[31]};
    diff     = rem_sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[sim/stream_directory_parser_tb.sv]
// ----------------------------------------------------------------------------
// stream_directory_parser_tb
// drives start commands and directory words through the parser and compares
// every result transfer with a cycle-free predictor of the parse, across
// several block size, block total and directory size settings
// ----------------------------------------------------------------------------
module stream_directory_parser_tb;
  import sdp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned RANDOM_ITEMS = 1900;

  typedef enum logic [1:0] {
    PH_IDLE, PH_COUNT, PH_SIZES, PH_BLOCKS
  } parse_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  stream_index;
    logic [31:0] strm_size;
    logic [29:0] block_position;
    logic [31:0] block_number;
    logic [63:0] block_offset;
    logic        last_of_stream;
    logic [2:0]  error_code;
    logic        last;
  } dir_result_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_index;
    logic        cmd;
    logic [31:0] word;
    bit          typed;
    logic [1:0]  kind;
    logic [2:0]  err;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [31:0] in_directory_word;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [9:0]  out_stream_index;
  logic [31:0] out_stream_size;
  logic [29:0] out_block_position;
  logic [31:0] out_block_number;
  logic [63:0] out_block_offset;
  logic        out_last_of_stream;
  logic [2:0]  out_error_code;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  stream_directory_parser DUT (.*);

  // predictor state
  logic [31:0]  cur_block_size = 32'd4096;
  logic [31:0]  cur_block_total = '0;
  logic [31:0]  cur_dir_size = '0;
  logic [31:0]  size_table [1024];
  parse_phase_t parse_phase = PH_IDLE;
  logic [31:0]  strm_total = '0;
  logic [31:0]  stream_cursor = '0;
  logic [63:0]  dir_cursor = '0;
  logic [31:0]  blocks_remaining = '0;
  logic [29:0]  block_pos = '0;

  dir_result_t  pending_results [$];
  int unsigned  cyc = 0;
  int unsigned  fail_count = 0;
  int unsigned  row_fail_count = 0;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic bit idle_now();
    if (cyc >= 20000 && cyc < 30000) return 1'b0;
    return $urandom_range(99) < 33;
  endfunction

  function automatic logic [31:0] blocks_for(logic [31:0] bytes);
    logic [31:0] sum;
    if (cur_block_size == 0) return '0;
    sum = bytes + cur_block_size - 32'd1;
    return sum / cur_block_size;
  endfunction

  function automatic void emit(logic [1:0] kind, logic [9:0] sidx, logic [31:0] ssize,
                               logic [29:0] pos, logic [31:0] num, logic [63:0] off,
                               logic los, logic [2:0] err);
    dir_result_t r;
    r = '{kind, sidx, ssize, pos, num, off, los, err, 1'b0};
    pending_results = {pending_results, r};
  endfunction

  function automatic void end_parse(logic [1:0] kind, logic [2:0] err);
    emit(kind, '0, '0, '0, '0, '0, 1'b0, err);
    parse_phase = PH_IDLE;
  endfunction

  function automatic void next_stream();
    logic [31:0] sz;
    logic [31:0] cnt;
    logic [63:0] bytes;
    while (stream_cursor < strm_total && stream_cursor < 1024) begin
      sz = size_table[stream_cursor];
      if (sz != EMPTY_SIZE) begin
        cnt = blocks_for(sz);
        bytes = 64'(cnt) * 4;
        if (dir_cursor > 64'(cur_dir_size) || bytes > 64'(cur_dir_size) - dir_cursor) begin
          end_parse(KIND_ERROR, ERR_BLOCKS_TRUNC);
          return;
        end
        if (cnt != 0) begin
          blocks_remaining = cnt;
          block_pos = '0;
          parse_phase = PH_BLOCKS;
          return;
        end
      end
      stream_cursor++;
    end
    end_parse(KIND_DONE, ERR_NONE);
  endfunction

  function automatic void predict_item(logic cmd, logic [31:0] w);
    int unsigned before_n;
    logic [63:0] table_bytes;
    logic [31:0] sz;
    before_n = pending_results.size();
    if (cmd == CMD_START) begin
      parse_phase = PH_IDLE;
      strm_total = '0;
      stream_cursor = '0;
      dir_cursor = '0;
      blocks_remaining = '0;
      block_pos = '0;
      if (cur_block_size == 0) end_parse(KIND_ERROR, ERR_TRUNCATED);
      else if (64'(blocks_for(cur_dir_size)) * 4 > 64'(cur_block_size))
        end_parse(KIND_ERROR, ERR_LIST_LARGE);
      else if (cur_dir_size < 4) end_parse(KIND_ERROR, ERR_TRUNCATED);
      else parse_phase = PH_COUNT;
    end else if (parse_phase == PH_COUNT) begin
      table_bytes = 64'd4 + 64'(w) * 4;
      if (w > 32'd1024) end_parse(KIND_ERROR, ERR_MANY_STRM);
      else if (table_bytes > 64'(cur_dir_size)) end_parse(KIND_ERROR, ERR_SIZES_TRUNC);
      else begin
        strm_total = w;
        stream_cursor = '0;
        dir_cursor = table_bytes;
        if (w == 0) next_stream();
        else parse_phase = PH_SIZES;
      end
    end else if (parse_phase == PH_SIZES) begin
      if (stream_cursor < 1024) size_table[stream_cursor] = w;
      stream_cursor++;
      if (stream_cursor >= strm_total) begin
        stream_cursor = '0;
        next_stream();
      end
    end else if (parse_phase == PH_BLOCKS) begin
      if (w >= cur_block_total) end_parse(KIND_ERROR, ERR_OUT_OF_RANGE);
      else begin
        sz = stream_cursor < 1024 ? size_table[stream_cursor] : '0;
        emit(KIND_ENTRY, stream_cursor[9:0], sz, block_pos, w,
             64'(w) * 64'(cur_block_size), blocks_remaining == 1, ERR_NONE);
        block_pos = block_pos + 30'd1;
        blocks_remaining--;
        dir_cursor += 4;
        if (blocks_remaining == 0) begin
          stream_cursor++;
          next_stream();
        end
      end
    end
    if (pending_results.size() > before_n)
      pending_results[pending_results.size() - 1].last = 1'b1;
  endfunction

  task automatic send_item(logic cmd, logic [31:0] w);
    if (idle_now()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (idle_now());
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_directory_word <= w;
    predict_item(cmd, w);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || !in_ready);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BLOCK_SIZE:  cur_block_size = val;
      REG_BLOCK_TOTAL: cur_block_total = val;
      default:         cur_dir_size = val;
    endcase
  endtask

  task automatic set_regs(logic [31:0] bs, logic [31:0] bt, logic [31:0] ds);
    write_reg(REG_BLOCK_SIZE, bs);
    write_reg(REG_BLOCK_TOTAL, bt);
    write_reg(REG_DIR_SIZE, ds);
  endtask

  function automatic logic [31:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return EMPTY_SIZE;
    if (r < 15) return '0;
    if (r < 20) return $urandom;
    return $urandom_range(3 * 4096);
  endfunction

  function automatic logic [31:0] pick_block();
    if ($urandom_range(99) < 5 || cur_block_total == 0) return $urandom;
    if ($urandom_range(99) < 3) return cur_block_total - 1;
    return $urandom_range(0, cur_block_total - 1);
  endfunction

  // one parse with random content, sometimes malformed or broken off
  task automatic random_parse(inout int unsigned sent);
    int unsigned n;
    send_item(CMD_START, $urandom);
    sent++;
    if ($urandom_range(99) < 8) begin
      send_item(CMD_WORD, $urandom);
      sent++;
      return;
    end
    n = $urandom_range(99) < 90 ? $urandom_range(0, 8) : $urandom_range(9, 40);
    if ($urandom_range(99) < 3) n = $urandom_range(1025, 1100);
    send_item(CMD_WORD, n);
    sent++;
    while (parse_phase == PH_SIZES) begin
      send_item(CMD_WORD, pick_size());
      sent++;
    end
    while (parse_phase == PH_BLOCKS && sent < RANDOM_ITEMS + 200) begin
      if ($urandom_range(199) == 0) begin
        send_item(CMD_START, $urandom);
        sent++;
        return;
      end
      send_item(CMD_WORD, pick_block());
      sent++;
    end
    if ($urandom_range(99) < 10) begin
      send_item(CMD_WORD, $urandom);
      sent++;
    end
  endtask

  task automatic check_result(dir_result_t e);
    if (out_kind !== e.kind) begin
      $error("kind exp %0d got %0d", e.kind, out_kind); fail_count++;
    end
    if (out_stream_index !== e.stream_index) begin
      $error("stream_index exp %0d got %0d", e.stream_index, out_stream_index); fail_count++;
    end
    if (out_stream_size !== e.strm_size) begin
      $error("out_stream_size exp %0h got %0h", e.strm_size, out_stream_size); fail_count++;
    end
    if (out_block_position !== e.block_position) begin
      $error("block_position exp %0d got %0d", e.block_position, out_block_position);
      fail_count++;
    end
    if (out_block_number !== e.block_number) begin
      $error("block_number exp %0h got %0h", e.block_number, out_block_number); fail_count++;
    end
    if (out_block_offset !== e.block_offset) begin
      $error("block_offset exp %0h got %0h", e.block_offset, out_block_offset); fail_count++;
    end
    if (out_last_of_stream !== e.last_of_stream) begin
      $error("last_of_stream exp %0b got %0b", e.last_of_stream, out_last_of_stream);
      fail_count++;
    end
    if (out_error_code !== e.error_code) begin
      $error("error_code exp %0d got %0d", e.error_code, out_error_code); fail_count++;
    end
    if (out_last !== e.last) begin
      $error("last exp %0b got %0b", e.last, out_last); fail_count++;
    end
  endtask

  // receiver side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && cyc >= 10000 && in_valid) begin
        hold_left <= 400;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_now();
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          check_result(pending_results.pop_front());
        end
      end
    end
  end

  dir_row_t directed [] = '{
    '{0, REG_BLOCK_SIZE, CMD_START, 32'd0, 1, KIND_ERROR, ERR_TRUNCATED},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'hFFFF_FFFF, 0, KIND_ENTRY, ERR_NONE},
    '{1, REG_DIR_SIZE, CMD_START, 32'd4096, 0, KIND_ENTRY, ERR_NONE},
    '{1, REG_BLOCK_TOTAL, CMD_START, 32'd100, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_START, 32'd0, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd1025, 1, KIND_ERROR, ERR_MANY_STRM},
    '{0, REG_BLOCK_SIZE, CMD_START, 32'd0, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd1024, 1, KIND_ERROR, ERR_SIZES_TRUNC},
    '{0, REG_BLOCK_SIZE, CMD_START, 32'd0, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd2, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd5000, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, EMPTY_SIZE, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd7, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd100, 1, KIND_ERROR, ERR_OUT_OF_RANGE},
    '{0, REG_BLOCK_SIZE, CMD_START, 32'd0, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd3, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd0, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd4096, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd1, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd99, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_START, 32'd0, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd0, 1, KIND_DONE, ERR_NONE},
    '{1, REG_BLOCK_SIZE, CMD_START, 32'd0, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_START, 32'd0, 1, KIND_ERROR, ERR_TRUNCATED},
    '{1, REG_BLOCK_SIZE, CMD_START, 32'd1, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_START, 32'd0, 1, KIND_ERROR, ERR_LIST_LARGE},
    '{1, REG_BLOCK_SIZE, CMD_START, 32'd4096, 0, KIND_ENTRY, ERR_NONE},
    '{1, REG_DIR_SIZE, CMD_START, 32'd20, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_START, 32'd0, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd1, 0, KIND_ENTRY, ERR_NONE},
    '{0, REG_BLOCK_SIZE, CMD_WORD, 32'd20480, 1, KIND_ERROR, ERR_BLOCKS_TRUNC}
  };

  initial begin
    int unsigned sent;
    int unsigned setting;
    int unsigned phase_end;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = 1'b0;
    in_directory_word = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_reg(directed[i].reg_index, directed[i].word);
      end else begin
        send_item(directed[i].cmd, directed[i].word);
        if (directed[i].typed &&
            (pending_results.size() == 0 ||
             pending_results[pending_results.size() - 1].kind != directed[i].kind ||
             pending_results[pending_results.size() - 1].error_code != directed[i].err)) begin
          $error("row %0d: kind/error_code exp %0d/%0d", i, directed[i].kind, directed[i].err);
          row_fail_count++;
        end
      end
    end

    // zero block size written in the middle of a parse
    set_regs(32'd512, 32'd64, 32'd4096);
    send_item(CMD_START, '0);
    send_item(CMD_WORD, 32'd2);
    send_item(CMD_WORD, 32'd700);
    write_reg(REG_BLOCK_SIZE, '0);
    send_item(CMD_WORD, 32'd900);

    sent = 0;
    setting = 0;
    while (sent < RANDOM_ITEMS) begin
      case (setting % 5)
        0: set_regs(32'd4096, $urandom_range(1, 5000), 32'd4096);
        1: set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: set_regs(32'd512, $urandom_range(0, 64), $urandom_range(4, 700));
        3: set_regs(32'd1, 32'hFFFF_FFFF, $urandom_range(0, 4));
        default: set_regs($urandom_range(16, 8192), $urandom, $urandom_range(4, 2048));
      endcase
      setting++;
      phase_end = sent + 350;
      while (sent < phase_end && sent < RANDOM_ITEMS) begin
        if ($urandom_range(99) < 85) random_parse(sent);
        else begin
          send_item($urandom_range(1), $urandom);
          sent++;
        end
        if ($urandom_range(99) < 3) wait_drained();
      end
    end

    wait_drained();
    if (fail_count == 0 && row_fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
